/* rtl/core/mandelbrot_escape_time_pixel_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel block
// Shared property shapes, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/met_pkg.sv */
// ----------------------------------------------------------------------------
// met_pkg
// Widths, sequencer states and multiplier handshake types of the block.
// ----------------------------------------------------------------------------
package met_pkg;

	localparam int PX_W    = 12;  // pixel index
	localparam int ITER_W  = 16;  // iteration count
	localparam int Q_W     = 48;  // signed Q4.44 coordinate
	localparam int STEP_W  = 47;  // unsigned Q3.44 step
	localparam int FRAC_W  = 44;  // fraction bits
	localparam int Z_W     = 49;  // orbit component, |z| < 16
	localparam int PROD_W  = 53;  // product after the fraction shift
	localparam int EXT_W   = PROD_W + 1;
	localparam int HALF_W  = 24;  // low slice of a multiplier operand
	localparam int PART_W  = Z_W - HALF_W;  // signed partial operand
	localparam int ACC_W   = 2 * Z_W;       // exact full product
	localparam int CFG_W   = 48;
	localparam int IDX_W   = 3;

	typedef logic [IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_X_MIN    = 3'd0;
	localparam reg_idx_t REG_Y_MIN    = 3'd1;
	localparam reg_idx_t REG_X_STEP   = 3'd2;
	localparam reg_idx_t REG_Y_STEP   = 3'd3;
	localparam reg_idx_t REG_MAX_ITER = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PT_X,
		ST_PT_Y,
		ST_PT_C,
		ST_XY_GO,
		ST_XY_WAIT,
		ST_ZR_GO,
		ST_ZR_WAIT,
		ST_ZI_GO,
		ST_ZI_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                  start;
		logic signed [Z_W-1:0] a;
		logic signed [Z_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

endpackage

/* rtl/core/mandelbrot_escape_time_pixel_top.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// Escape-time evaluator for one pixel of the Mandelbrot set, Q4.44 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Write the window (x_min, y_min, x_step, y_step) and max_iter through the
//   cfg_we / cfg_index / cfg_wdata port while no pixel is in flight.
//   Send one pixel per transaction on s_axis: tdata = {py, px}. The block
//   forms c, iterates z = z*z + c, and returns one transaction on m_axis with
//   the pixel, the escape flag (tuser) and count and colour (tdata).
// Sequencing:
//   One pixel at a time; a new one is taken once the previous result is
//   parked in the output register. After acceptance the sequencer forms
//   c, then runs the iterations until escape or max_iter, then parks the result.
//   Each iteration runs three products through one shared multiplier
//   that takes four 25x25 partial products. The point c takes a 12x47
//   product and a saturating add per axis.
// Reset:
//   arst_n clears the sequencer and the output valid and restores the
//   registers to a window from -2 on both axes at about 0.004 per pixel, 20000 iterations.
// Back-pressure:
//   The result waits in the output register while m_axis_tready is low;
//   s_axis_tready returns high as soon as the result is parked there, so the
//   next pixel can start while the previous result still waits.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_top_macros.svh"

module mandelbrot_escape_time_pixel_top #(
	parameter int COORD_MAX = 4095
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [met_pkg::IDX_W-1:0]     cfg_index,
	input  logic [met_pkg::CFG_W-1:0]     cfg_wdata,
	// pixel input
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,   // px[11:0], py[23:12]
	// result output
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_px[11:0], out_py[23:12], iter_count[39:24], red[46:40],
	// green[53:47], blue[59:54], zero pad[63:60]
	output logic [63:0]                   m_axis_tdata,
	output logic [0:0]                    m_axis_tuser    // escaped[0]
);

	localparam int PXW  = met_pkg::PX_W;
	localparam int ITW  = met_pkg::ITER_W;
	localparam int QW   = met_pkg::Q_W;
	localparam int SW   = met_pkg::STEP_W;
	localparam int ZW   = met_pkg::Z_W;
	localparam int RW   = met_pkg::PROD_W;
	localparam int EW   = met_pkg::EXT_W;
	localparam int FW   = met_pkg::FRAC_W;
	localparam int PMW  = PXW + SW;     // index times step
	localparam int PTW  = PMW + 1;      // point sum, signed

	localparam logic [PXW-1:0]        CoordMaxC = PXW'(COORD_MAX);
	localparam logic signed [PTW-1:0] SatMax    = {{(PTW-QW+1){1'b0}}, {(QW-1){1'b1}}};
	localparam logic signed [EW-1:0]  FourQ     = EW'(4) <<< FW;
	localparam int                    ColorUnit = 25;

	localparam logic [QW-1:0]  XMinRst    = 48'hE000_0000_0000;
	localparam logic [QW-1:0]  YMinRst    = 48'hE000_0000_0000;
	localparam logic [SW-1:0]  XStepRst   = 47'd70368744177;
	localparam logic [SW-1:0]  YStepRst   = 47'd70368744177;
	localparam logic [ITW-1:0] MaxIterRst = 16'd20000;

	// configuration registers
	logic signed [QW-1:0] x_min_q;
	logic signed [QW-1:0] y_min_q;
	logic [SW-1:0]        x_step_q;
	logic [SW-1:0]        y_step_q;
	logic [ITW-1:0]       max_iter_q;

	// sequencer
	met_pkg::state_t state_q;
	met_pkg::state_t state_d;
	logic            out_load;

	// per-pixel working registers
	logic [PXW-1:0]        px_q;
	logic [PXW-1:0]        py_q;
	logic [ITW-1:0]        limit_q;
	logic [PMW-1:0]        pmul_q;
	logic signed [QW-1:0]  cr_q;
	logic signed [QW-1:0]  ci_q;
	logic signed [ZW-1:0]  zr_q;
	logic signed [ZW-1:0]  zi_q;
	logic signed [RW-1:0]  zr2_q;
	logic signed [RW-1:0]  zi2_q;
	logic [ITW-1:0]        k_q;
	logic [2:0]            m5_q;
	logic [1:0]            m4_q;
	logic [1:0]            m3_q;
	logic                  esc_q;

	// output register
	logic                  out_valid_q;
	logic [PXW-1:0]        out_px_q;
	logic [PXW-1:0]        out_py_q;
	logic                  out_esc_q;
	logic [ITW-1:0]        iter_q;
	logic [6:0]            red_q;
	logic [6:0]            green_q;
	logic [5:0]            blue_q;

	// combinational datapath
	logic [PXW-1:0]        px_in;
	logic [PXW-1:0]        py_in;
	logic [PXW-1:0]        pt_idx;
	logic [SW-1:0]         pt_step;
	logic signed [QW-1:0]  pt_base;
	logic signed [PTW-1:0] pt_sum;
	logic signed [QW-1:0]  pt_sat;
	logic signed [EW-1:0]  sum_r;
	logic signed [EW-1:0]  sum_i;
	logic signed [EW-1:0]  mag2;
	logic                  escape;
	logic                  last_iter;
	logic [ITW-1:0]        k_next;

	// status terms for the checks
	logic                  mul_wait;
	logic                  iter_go;
	logic                  out_inside;
	logic                  out_black;

	met_pkg::mul_req_t mul_req;
	met_pkg::mul_rsp_t mul_rsp;

	met_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Clamp incoming indices to the coordinate limit.
	assign px_in = (s_axis_tdata[PXW-1:0] > CoordMaxC) ? CoordMaxC : s_axis_tdata[PXW-1:0];
	assign py_in = (s_axis_tdata[2*PXW-1:PXW] > CoordMaxC) ? CoordMaxC
		: s_axis_tdata[2*PXW-1:PXW];

	// Point c: index times step, plus base, saturated at the top of Q4.44.
	// The step is never negative, so the sum can't fall below the base range.
	assign pt_idx  = (state_q == met_pkg::ST_PT_X) ? px_q : py_q;
	assign pt_step = (state_q == met_pkg::ST_PT_X) ? x_step_q : y_step_q;
	assign pt_base = (state_q == met_pkg::ST_PT_Y) ? x_min_q : y_min_q;
	assign pt_sum  = PTW'(pt_base) + signed'({1'b0, pmul_q});
	assign pt_sat  = (pt_sum > SatMax) ? QW'(SatMax) : pt_sum[QW-1:0];

	// Orbit update from the cross product and the stored squares.
	assign sum_r = EW'(zr2_q) - EW'(zi2_q) + EW'(cr_q);
	assign sum_i = signed'({mul_rsp.prod, 1'b0}) + EW'(ci_q);

	// Escape test on |z|^2 once the second square arrives; exactly 4 stays in.
	assign mag2      = EW'(zr2_q) + EW'(mul_rsp.prod);
	assign escape    = mag2 > FourQ;
	assign k_next    = k_q + 1'b1;
	assign last_iter = (k_next == limit_q);

	assign s_axis_tready = (state_q == met_pkg::ST_IDLE);

	// Next state and multiplier issue.
	always_comb begin
		state_d       = state_q;
		mul_req.start = 1'b0;
		mul_req.a     = zr_q;
		mul_req.b     = zi_q;
		out_load      = 1'b0;
		unique case (state_q)
			met_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = met_pkg::ST_PT_X;
				end
			end
			met_pkg::ST_PT_X: state_d = met_pkg::ST_PT_Y;
			met_pkg::ST_PT_Y: state_d = met_pkg::ST_PT_C;
			met_pkg::ST_PT_C: begin
				state_d = (limit_q == '0) ? met_pkg::ST_FINISH : met_pkg::ST_XY_GO;
			end
			met_pkg::ST_XY_GO: begin
				mul_req.start = 1'b1;
				state_d       = met_pkg::ST_XY_WAIT;
			end
			met_pkg::ST_XY_WAIT: begin
				if (mul_rsp.done) begin
					state_d = met_pkg::ST_ZR_GO;
				end
			end
			met_pkg::ST_ZR_GO: begin
				mul_req.start = 1'b1;
				mul_req.b     = zr_q;
				state_d       = met_pkg::ST_ZR_WAIT;
			end
			met_pkg::ST_ZR_WAIT: begin
				if (mul_rsp.done) begin
					state_d = met_pkg::ST_ZI_GO;
				end
			end
			met_pkg::ST_ZI_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = zi_q;
				state_d       = met_pkg::ST_ZI_WAIT;
			end
			met_pkg::ST_ZI_WAIT: begin
				if (mul_rsp.done) begin
					state_d = (escape || last_iter) ? met_pkg::ST_FINISH : met_pkg::ST_XY_GO;
				end
			end
			met_pkg::ST_FINISH: begin
				// park the result once the output register is free
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = met_pkg::ST_IDLE;
				end
			end
			default: state_d = met_pkg::ST_IDLE;
		endcase
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= met_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			x_min_q     <= signed'(XMinRst);
			y_min_q     <= signed'(YMinRst);
			x_step_q    <= XStepRst;
			y_step_q    <= YStepRst;
			max_iter_q  <= MaxIterRst;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					met_pkg::REG_X_MIN:    x_min_q    <= signed'(cfg_wdata);
					met_pkg::REG_Y_MIN:    y_min_q    <= signed'(cfg_wdata);
					met_pkg::REG_X_STEP:   x_step_q   <= cfg_wdata[SW-1:0];
					met_pkg::REG_Y_STEP:   y_step_q   <= cfg_wdata[SW-1:0];
					met_pkg::REG_MAX_ITER: max_iter_q <= cfg_wdata[ITW-1:0];
					default: ;  // drop writes past the register list
				endcase
			end
		end
	end

	// Per-pixel datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			met_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					px_q    <= px_in;
					py_q    <= py_in;
					limit_q <= max_iter_q;
				end
			end
			met_pkg::ST_PT_X: begin
				pmul_q <= PMW'(pt_idx) * PMW'(pt_step);
			end
			met_pkg::ST_PT_Y: begin
				cr_q   <= pt_sat;
				pmul_q <= PMW'(pt_idx) * PMW'(pt_step);
			end
			met_pkg::ST_PT_C: begin
				ci_q  <= pt_sat;
				zr_q  <= '0;
				zi_q  <= '0;
				zr2_q <= '0;
				zi2_q <= '0;
				k_q   <= '0;
				m5_q  <= '0;
				m4_q  <= '0;
				m3_q  <= '0;
				esc_q <= 1'b0;
			end
			met_pkg::ST_XY_WAIT: begin
				if (mul_rsp.done) begin
					zr_q <= sum_r[ZW-1:0];
					zi_q <= sum_i[ZW-1:0];
				end
			end
			met_pkg::ST_ZR_WAIT: begin
				if (mul_rsp.done) begin
					zr2_q <= mul_rsp.prod;
				end
			end
			met_pkg::ST_ZI_WAIT: begin
				if (mul_rsp.done) begin
					zi2_q <= mul_rsp.prod;
					if (escape) begin
						esc_q <= 1'b1;
					end else begin
						// advance the count and its residues together
						k_q  <= k_next;
						m5_q <= (m5_q == 3'd4) ? 3'd0 : m5_q + 3'd1;
						m4_q <= m4_q + 2'd1;
						m3_q <= (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
					end
				end
			end
			default: ;
		endcase

		if (out_load) begin
			out_px_q  <= px_q;
			out_py_q  <= py_q;
			out_esc_q <= esc_q;
			iter_q    <= esc_q ? k_q : limit_q;
			red_q     <= esc_q ? 7'(ColorUnit * m5_q) : 7'd0;
			green_q   <= esc_q ? 7'(ColorUnit * m4_q) : 7'd0;
			blue_q    <= esc_q ? 6'(ColorUnit * m3_q) : 6'd0;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {4'b0000, blue_q, green_q, red_q, iter_q, out_py_q, out_px_q};
	assign m_axis_tuser[0] = out_esc_q;

	assign mul_wait   = (state_q == met_pkg::ST_XY_WAIT) || (state_q == met_pkg::ST_ZR_WAIT)
		|| (state_q == met_pkg::ST_ZI_WAIT);
	assign iter_go    = (state_q == met_pkg::ST_XY_GO);
	assign out_inside = out_valid_q && !out_esc_q;
	assign out_black  = (red_q == 7'd0) && (green_q == 7'd0) && (blue_q == 6'd0);

	// A product only comes back while the sequencer waits for one.
	`MET_ASSERT_SAME(a_done_in_wait, mul_rsp.done, mul_wait, "product outside a wait state")
	// Every issued product is followed by its wait state.
	`MET_ASSERT_NEXT(a_issue_waits, mul_req.start, mul_wait, "product issued without a wait")
	// A new iteration only starts below the latched limit.
	`MET_ASSERT_SAME(a_iter_below_limit, iter_go, k_q < limit_q, "iteration past the limit")
	// Points that stay inside are reported black.
	`MET_ASSERT_SAME(a_inside_black, out_inside, out_black, "inside point not black")

endmodule

/* rtl/core/met_mul.sv */
// ----------------------------------------------------------------------------
// met_mul
// Shared signed Q5.44 multiplier: four 25x25 partial products accumulated
// in turn, result floor-shifted by the fraction width.
// ----------------------------------------------------------------------------
module met_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  met_pkg::mul_req_t  req,
	output met_pkg::mul_rsp_t  rsp
);

	localparam int ZW  = met_pkg::Z_W;
	localparam int HW  = met_pkg::HALF_W;
	localparam int PW  = met_pkg::PART_W;
	localparam int AW  = met_pkg::ACC_W;
	localparam int FW  = met_pkg::FRAC_W;
	localparam int RW  = met_pkg::PROD_W;
	localparam logic [1:0] LastStep = 2'd3;

	logic                 busy_q;
	logic [1:0]           step_q;
	logic                 done_q;
	logic signed [ZW-1:0] a_q;
	logic signed [ZW-1:0] b_q;
	logic signed [AW-1:0] acc_q;

	logic signed [PW-1:0]   op_a;
	logic signed [PW-1:0]   op_b;
	logic [6:0]             shamt;
	logic signed [2*PW-1:0] part;
	logic signed [AW-1:0]   term;

	// Pick operand slices: low slices are zero-extended, high slices carry sign.
	always_comb begin
		unique case (step_q)
			2'd0: begin
				op_a  = signed'({1'b0, a_q[HW-1:0]});
				op_b  = signed'({1'b0, b_q[HW-1:0]});
				shamt = 7'd0;
			end
			2'd1: begin
				op_a  = signed'(a_q[ZW-1:HW]);
				op_b  = signed'({1'b0, b_q[HW-1:0]});
				shamt = 7'(HW);
			end
			2'd2: begin
				op_a  = signed'({1'b0, a_q[HW-1:0]});
				op_b  = signed'(b_q[ZW-1:HW]);
				shamt = 7'(HW);
			end
			default: begin
				op_a  = signed'(a_q[ZW-1:HW]);
				op_b  = signed'(b_q[ZW-1:HW]);
				shamt = 7'(2 * HW);
			end
		endcase
		part = op_a * op_b;
		term = AW'(part) <<< shamt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == LastStep);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == LastStep) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + term;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = signed'(acc_q[FW+RW-1:FW]);

endmodule
